@@ rtl/lzss_stream_decoder_macros.svh @@
// assertion macros for the lzss stream decoder
`ifndef LZSS_STREAM_DECODER_MACROS_SVH
`define LZSS_STREAM_DECODER_MACROS_SVH

// same-cycle implication under reset
`define LSD_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define LSD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lsd_pkg.sv @@
// shared constants and types for the lzss stream decoder
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

	localparam int RING_SIZE       = 4096;
	localparam int RING_AW         = $clog2(RING_SIZE);
	localparam int MAX_MATCH       = 18;
	localparam int MATCH_THRESHOLD = 2;
	localparam int LEN_W           = $clog2(MAX_MATCH + 1);
	localparam int FILL_W          = RING_AW + 1;

	localparam logic [RING_AW-1:0] WPTR_START = RING_AW'(RING_SIZE - MAX_MATCH);
	localparam logic [7:0]         SPACE_BYTE = 8'h20;
	localparam logic [31:0]        CAP_RESET  = 32'd65536;

	localparam int M_TDATA_RAW = 8 + 1 + 32;
	localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_REPORT
	} lsd_state_t;

endpackage

`default_nettype wire

@@ rtl/lzss_stream_decoder.sv @@
// lzss stream decoder: 4096-byte ring; no input is taken until the current token is done
// steps: a flag byte is taken in idle alone; a literal goes from idle straight to write;
// a match takes two bytes, then each of its 3 to 18 bytes passes read, then write
// report: follows the last data byte's write; output stalls hold write and report states
// reset: control cleared, ring contents undefined; a fill count makes unwritten
// entries read as space, so there is no clearing pass after reset or stream start
`timescale 1ns / 1ps
`default_nettype none
`include "lzss_stream_decoder_macros.svh"

module lzss_stream_decoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,  // in_byte
	input  wire logic                         s_tlast,  // last_in
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [lsd_pkg::M_TDATA_W-1:0]     m_tdata,  // out_byte, status, total_out
	output logic                              m_tuser,  // kind
	output logic                              m_tlast,  // run_last
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [31:0]                  cfg_data  // out_capacity
);

	localparam int AW = lsd_pkg::RING_AW;
	localparam int LW = lsd_pkg::LEN_W;
	localparam int FW = lsd_pkg::FILL_W;

	lsd_pkg::lsd_state_t state_q, state_d;

	logic [7:0]    ring_mem [lsd_pkg::RING_SIZE];
	logic [7:0]    rd_data_q;
	logic          rd_ok_q;

	logic [31:0]   cap_q;
	logic [AW-1:0] wr_ptr_q;
	logic [FW-1:0] fill_q;
	logic [8:0]    flag_q;
	logic [7:0]    pend_q;
	logic          await_q;
	logic [31:0]   produced_q;
	logic          ovf_q;

	logic [AW-1:0] pos_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] k_q;
	logic [7:0]    hold_q;
	logic          src_lit_q;
	logic          last_q;

	logic                        m_valid_q;
	logic [lsd_pkg::M_TDATA_W-1:0] m_data_q;
	logic                        m_user_q;
	logic                        m_last_q;

	logic          accept;
	logic          out_can;
	logic          step;
	logic          emit;
	logic          byte_final;
	logic          rep_go;
	logic [7:0]    cur_byte;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] rd_rel;
	logic          flag_due;

	assign s_tready  = (state_q == lsd_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_user_q;
	assign m_tlast   = m_last_q;

	assign accept     = s_tvalid && s_tready;
	assign out_can    = !m_valid_q || m_tready;
	assign step       = (state_q == lsd_pkg::ST_WRITE) && out_can;
	assign emit       = step && !ovf_q && (produced_q < cap_q);
	assign byte_final = (k_q == len_q - LW'(1));
	assign rep_go     = (state_q == lsd_pkg::ST_REPORT) && out_can;
	assign cur_byte   = src_lit_q ? hold_q : (rd_ok_q ? rd_data_q : lsd_pkg::SPACE_BYTE);
	assign rd_addr    = pos_q + AW'(k_q);
	assign rd_rel     = rd_addr - lsd_pkg::WPTR_START;
	assign flag_due   = (flag_q[8:1] == 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsd_pkg::ST_IDLE: begin
				if (accept) begin
					if (await_q) begin
						state_d = lsd_pkg::ST_READ;
					end else if (!flag_due && flag_q[0]) begin
						state_d = lsd_pkg::ST_WRITE;
					end else if (s_tlast) begin
						state_d = lsd_pkg::ST_REPORT;
					end
				end
			end
			lsd_pkg::ST_READ: begin
				state_d = lsd_pkg::ST_WRITE;
			end
			lsd_pkg::ST_WRITE: begin
				if (out_can) begin
					if (!byte_final) begin
						state_d = lsd_pkg::ST_READ;
					end else if (last_q) begin
						state_d = lsd_pkg::ST_REPORT;
					end else begin
						state_d = lsd_pkg::ST_IDLE;
					end
				end
			end
			lsd_pkg::ST_REPORT: begin
				if (out_can) begin
					state_d = lsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lsd_pkg::ST_IDLE;
			end
		endcase
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (step) begin
			ring_mem[wr_ptr_q] <= cur_byte;
		end
		if (state_q == lsd_pkg::ST_READ) begin
			rd_data_q <= ring_mem[rd_addr];
			rd_ok_q   <= (FW'(rd_rel) < fill_q);
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= s_tlast;
			hold_q <= s_tdata;
			pos_q  <= {s_tdata[7:4], pend_q};
			k_q    <= '0;
			if (await_q) begin
				src_lit_q <= 1'b0;
				len_q     <= LW'(s_tdata[3:0]) + LW'(lsd_pkg::MATCH_THRESHOLD + 1);
			end else begin
				src_lit_q <= 1'b1;
				len_q     <= LW'(1);
			end
		end else if (step) begin
			k_q <= k_q + LW'(1);
		end
	end

	// stream state and capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= lsd_pkg::CAP_RESET;
			wr_ptr_q   <= lsd_pkg::WPTR_START;
			fill_q     <= '0;
			flag_q     <= '0;
			pend_q     <= '0;
			await_q    <= 1'b0;
			produced_q <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				if (await_q) begin
					await_q <= 1'b0;
					flag_q  <= flag_q >> 1;
				end else if (flag_due) begin
					flag_q <= {1'b1, s_tdata};
				end else if (flag_q[0]) begin
					flag_q <= flag_q >> 1;
				end else begin
					pend_q  <= s_tdata;
					await_q <= 1'b1;
				end
			end
			if (step) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
				if (fill_q != FW'(lsd_pkg::RING_SIZE)) begin
					fill_q <= fill_q + FW'(1);
				end
				if (emit) begin
					produced_q <= produced_q + 32'd1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (rep_go) begin
				wr_ptr_q   <= lsd_pkg::WPTR_START;
				fill_q     <= '0;
				flag_q     <= '0;
				pend_q     <= '0;
				await_q    <= 1'b0;
				produced_q <= '0;
				ovf_q      <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit || rep_go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= lsd_pkg::M_TDATA_W'(cur_byte);
			m_user_q <= lsd_pkg::KIND_DATA;
			m_last_q <= !last_q && (byte_final || (produced_q + 32'd1 == cap_q));
		end else if (rep_go) begin
			m_data_q <= lsd_pkg::M_TDATA_W'({(ovf_q ? 32'd0 : produced_q), ovf_q, 8'd0});
			m_user_q <= lsd_pkg::KIND_REPORT;
			m_last_q <= 1'b1;
		end
	end

	`LSD_ASSERT_NOW(a_report_shape, clk, arst_n,
		m_tvalid && (m_tuser == lsd_pkg::KIND_REPORT),
		(m_tdata[7:0] == 8'd0) && m_tlast, "report carries data byte or lacks run_last")
	`LSD_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1,
		fill_q <= FW'(lsd_pkg::RING_SIZE), "ring fill count beyond ring size")
	`LSD_ASSERT_NOW(a_copy_index, clk, arst_n,
		(state_q == lsd_pkg::ST_WRITE) || (state_q == lsd_pkg::ST_READ),
		k_q < len_q, "copy index past token length")
	`LSD_ASSERT_NEXT(a_stream_fresh, clk, arst_n, rep_go,
		(wr_ptr_q == lsd_pkg::WPTR_START) && (produced_q == 32'd0) && !ovf_q && (fill_q == '0),
		"stream state not fresh after report")

endmodule

`default_nettype wire
